@@ design/cslu_pkg.sv @@
// ----------------------------------------------------------------------------
// cslu_pkg
// Shared types, character codes and a hex helper for the C string literal
// unescaper.
// ----------------------------------------------------------------------------
package cslu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_BYTE = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_A   = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LX     = 8'h78;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  // Decoder verdict for one text byte.
  typedef struct packed {
    logic       emit;
    result_t    res;
    phase_t     phase_next;
    logic [3:0] nibble_next;
  } step_t;

  // Hex digit test: bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        hex_val = {1'b0, d[3:0]};
      end else if (c >= CH_LA && c <= CH_LF_A) begin
        d = c - CH_LA + 8'd10;
        hex_val = {1'b0, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
        hex_val = {1'b0, d[3:0]};
      end else begin
        hex_val = 5'h10;
      end
    end
  endfunction

endpackage

@@ design/cslu_decode.sv @@
// ----------------------------------------------------------------------------
// cslu_decode
// One-byte step of the literal parser: next phase, hex nibble and result.
// ----------------------------------------------------------------------------
module cslu_decode (
  input  logic [7:0]       text_byte,
  input  cslu_pkg::phase_t phase,
  input  logic [3:0]       high_nibble,
  output cslu_pkg::step_t  step
);

  logic [4:0] hv;

  assign hv = cslu_pkg::hex_val(text_byte);

  always_comb begin
    step             = '0;
    step.phase_next  = phase;
    step.nibble_next = high_nibble;
    step.res.status  = cslu_pkg::ST_BYTE;
    case (phase)
      cslu_pkg::PH_STR: begin
        if (text_byte == cslu_pkg::CH_NUL) begin
          step.emit          = 1'b1;
          step.res.status    = cslu_pkg::ST_BAD;
        end else if (text_byte == cslu_pkg::CH_QUOTE) begin
          step.emit          = 1'b1;
          step.res.status    = cslu_pkg::ST_DONE;
        end else if (text_byte == cslu_pkg::CH_BSLASH) begin
          step.phase_next    = cslu_pkg::PH_ESC;
        end else begin
          step.emit          = 1'b1;
          step.res.data      = text_byte;
        end
      end
      cslu_pkg::PH_ESC: begin
        step.phase_next = cslu_pkg::PH_STR;
        step.emit       = 1'b1;
        case (text_byte)
          cslu_pkg::CH_LN:     step.res.data = cslu_pkg::CH_LF;
          cslu_pkg::CH_LR:     step.res.data = cslu_pkg::CH_CR;
          cslu_pkg::CH_LT:     step.res.data = cslu_pkg::CH_TAB;
          cslu_pkg::CH_ZERO:   step.res.data = cslu_pkg::CH_NUL;
          cslu_pkg::CH_BSLASH: step.res.data = cslu_pkg::CH_BSLASH;
          cslu_pkg::CH_QUOTE:  step.res.data = cslu_pkg::CH_QUOTE;
          cslu_pkg::CH_LX: begin
            step.emit       = 1'b0;
            step.phase_next = cslu_pkg::PH_HEX1;
          end
          default:             step.res.status = cslu_pkg::ST_BAD;
        endcase
      end
      cslu_pkg::PH_HEX1: begin
        if (hv[4]) begin
          step.emit          = 1'b1;
          step.res.status    = cslu_pkg::ST_BAD;
        end else begin
          step.nibble_next   = hv[3:0];
          step.phase_next    = cslu_pkg::PH_HEX2;
        end
      end
      cslu_pkg::PH_HEX2: begin
        step.emit = 1'b1;
        if (hv[4]) begin
          step.res.status    = cslu_pkg::ST_BAD;
        end else begin
          step.res.data      = {high_nibble, hv[3:0]};
          step.phase_next    = cslu_pkg::PH_STR;
        end
      end
      default: begin
        // Idle, and any unused phase code: skip whitespace, wait for a quote, fault on any other byte.
        step.phase_next = cslu_pkg::PH_IDLE;
        if (text_byte == cslu_pkg::CH_SPACE || text_byte == cslu_pkg::CH_TAB ||
            text_byte == cslu_pkg::CH_CR || text_byte == cslu_pkg::CH_LF) begin
          step.emit = 1'b0;
        end else if (text_byte == cslu_pkg::CH_QUOTE) begin
          step.phase_next = cslu_pkg::PH_STR;
        end else begin
          step.emit       = 1'b1;
          step.res.status = cslu_pkg::ST_BAD;
        end
      end
    endcase
    // Any completion or fault drops back to idle and clears the nibble.
    step.res.last = (step.res.status != cslu_pkg::ST_BYTE);
    if (step.emit && step.res.last) begin
      step.phase_next  = cslu_pkg::PH_IDLE;
      step.nibble_next = 4'd0;
    end
  end

endmodule

@@ design/c_string_literal_unescaper.sv @@
// ----------------------------------------------------------------------------
// c_string_literal_unescaper
// Streaming decoder for one double-quoted C string literal at a time.
// ----------------------------------------------------------------------------
// Feed text one byte per transfer; a zero byte marks end of text. Leading
// space, tab, CR and LF are skipped, then an opening double quote is required.
// Each plain byte of the string comes out as a status 0 result; escapes \n \r
// \t \0 \\ \" and \xHH (either case) come out decoded. The closing quote gives
// status 1, any fault (missing quote, bad escape, bad hex digit, early end)
// gives status 2; both raise last and return the decoder to idle. The opening
// quote, backslashes, the x of a hex escape and its first digit, and skipped
// whitespace produce no result. Throughput is one text byte per cycle while
// the result channel does not stall: a byte is held in the input register,
// decoded there by the phase logic, and its result lands in the output
// register, which raises result_valid. The only loop is the 3-bit phase plus
// the 4-bit hex nibble, updated in the same cycle a byte leaves the input
// register, so back-to-back bytes never wait on each other.
// ----------------------------------------------------------------------------
module c_string_literal_unescaper (
  input  logic       clk,
  input  logic       rst,
  // text channel
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] decoded_byte,
  output logic [1:0] status,
  output logic       last
);

  // Input register.
  logic             in_full;
  logic [7:0]       in_byte;
  // Parser state.
  cslu_pkg::phase_t phase;
  logic [3:0]       high_nibble;
  // Output register.
  cslu_pkg::result_t res;

  cslu_pkg::step_t step;
  logic            out_free;
  logic            advance;
  logic            in_load;

  cslu_decode u_decode (
    .text_byte   (in_byte),
    .phase       (phase),
    .high_nibble (high_nibble),
    .step        (step)
  );

  // Output register can take a new result when empty or being drained.
  assign out_free = !result_valid || !result_stall;
  // Advance the held byte only when its result, if any, has a place to go.
  assign advance  = in_full && out_free;
  // Input register takes a byte when empty or emptying this cycle.
  assign text_stall = in_full && !advance;
  assign in_load    = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte <= text_byte;
    end
  end

  // Phase and nibble move once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cslu_pkg::PH_IDLE;
      high_nibble <= 4'd0;
    end else if (advance) begin
      phase       <= step.phase_next;
      high_nibble <= step.nibble_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && step.emit;
    end
  end

  // Hold the payload while stalled; load only a real result.
  always_ff @(posedge clk) begin
    if (out_free && advance && step.emit) begin
      res <= step.res;
    end
  end

  assign decoded_byte = res.data;
  assign status       = res.status;
  assign last         = res.last;

endmodule
